// ----- rtl/core/mrtu_pkg.sv -----
`default_nettype none

package mrtu_pkg;

  // action codes of an input item
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // closing status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_TIMEOUT = 3'd1;
  localparam logic [2:0] ST_SHORT   = 3'd2;
  localparam logic [2:0] ST_CRC     = 3'd3;
  localparam logic [2:0] ST_ADDR    = 3'd4;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [15:0] SILENCE_RESET   = 16'd4;
  localparam logic [14:0] GAP_LIMIT_MIN   = 15'd2;
  localparam logic [14:0] GAP_LIMIT_RESET = SILENCE_RESET[15:1];
  localparam logic [8:0]  COUNT_MAX       = 9'd511;
  localparam logic [8:0]  MIN_FRAME_LEN   = 9'd4;
  localparam logic [15:0] GAP_MAX         = 16'hFFFF;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  unit_id;
    logic [15:0] timeout_ticks;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        is_function_code;
    logic [2:0]  status;
    logic        frame_done;
    logic [8:0]  frame_length;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/mrtu_in_if.sv -----
`default_nettype none

interface mrtu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  unit_id;
  logic [15:0] timeout_ticks;
  logic [7:0]  rx_byte;

  modport source (output valid, output action, output unit_id, output timeout_ticks,
                  output rx_byte, input ready);
  modport sink (input valid, input action, input unit_id, input timeout_ticks,
                input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mrtu_out_if.sv -----
`default_nettype none

interface mrtu_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic       is_function_code;
  logic [2:0] status;
  logic       frame_done;
  logic [8:0] frame_length;

  modport source (output valid, output kind, output payload_byte, output is_function_code,
                  output status, output frame_done, output frame_length, input ready);
  modport sink (input valid, input kind, input payload_byte, input is_function_code,
                input status, input frame_done, input frame_length, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/modbus_rtu_response_receiver_top.sv -----
// modbus rtu response receiver
//
// in_ch carries one item per handshake: a start (unit_id, timeout_ticks),
// a received byte (rx_byte) or one tick of time. out_ch carries payload
// bytes (function code first, then data, two bytes behind the line) and
// one closing status per transaction with frame_done set.
// cfg_we / cfg_wdata write silence_ticks; the gap limit max(silence/2, 2)
// is derived at the write, so write it only while the block is idle.
//
// an accepted item waits in the input register and is processed as it
// moves on, its result, if any, going into the output register and onto
// out_ch: one item per cycle sustained while out_ch does not stall. the
// per-byte crc is eight combinational xor/shift steps.
// when out_ch stalls, the input register holds one more item and in_ch
// ready drops until the output register empties.
// reset (rst, synchronous) empties both registers, returns the block to
// idle and sets silence_ticks back to 4.
`default_nettype none

module modbus_rtu_response_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  mrtu_in_if.sink          in_ch,
  mrtu_out_if.source       out_ch
);
  import mrtu_pkg::*;

  logic                s1_valid;
  in_item_t            s1_item;
  logic                out_valid;
  out_item_t           out_item;
  logic                advance;
  logic                in_accept;
  logic [14:0]         gap_limit;
  logic [14:0]         gap_limit_next;
  logic                res_valid;
  out_item_t           res;

  // output register free or being emptied this cycle
  assign advance   = !out_valid || out_ch.ready;
  assign in_ch.ready = !s1_valid || advance;
  assign in_accept = in_ch.valid && in_ch.ready;

  // gap limit: half the silence, never below two ticks
  assign gap_limit_next = (cfg_wdata[15:1] < GAP_LIMIT_MIN) ? GAP_LIMIT_MIN : cfg_wdata[15:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit <= GAP_LIMIT_RESET;
    end else if (cfg_we) begin
      gap_limit <= gap_limit_next;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item.action        <= in_ch.action;
      s1_item.unit_id       <= in_ch.unit_id;
      s1_item.timeout_ticks <= in_ch.timeout_ticks;
      s1_item.rx_byte       <= in_ch.rx_byte;
    end
  end

  // transaction state and per-item decision
  mrtu_frame_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_valid && advance),
    .item      (s1_item),
    .gap_limit (gap_limit),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && res_valid) begin
      out_item <= res;
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.kind             = out_item.kind;
  assign out_ch.payload_byte     = out_item.payload_byte;
  assign out_ch.is_function_code = out_item.is_function_code;
  assign out_ch.status           = out_item.status;
  assign out_ch.frame_done       = out_item.frame_done;
  assign out_ch.frame_length     = out_item.frame_length;

endmodule

`default_nettype wire

// ----- rtl/core/mrtu_crc_byte.sv -----
`default_nettype none

module mrtu_crc_byte (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data,
  output logic      [15:0] crc_out
);
  import mrtu_pkg::*;

  // reflected crc-16, one bit per step
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

// ----- rtl/core/mrtu_frame_ctl.sv -----
`default_nettype none

module mrtu_frame_ctl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire mrtu_pkg::in_item_t item,
  input  wire logic [14:0]        gap_limit,
  output logic                    res_valid,
  output mrtu_pkg::out_item_t     res
);
  import mrtu_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_RECV = 2'd2;

  logic [1:0]  phase, phase_next;
  logic [7:0]  expected_address, expected_address_next;
  logic [15:0] ticks_left, ticks_left_next;
  logic [15:0] gap_count, gap_count_next;
  logic [8:0]  byte_count, byte_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  held0, held0_next;
  logic [7:0]  held1, held1_next;
  logic [7:0]  address_seen, address_seen_next;

  logic [15:0] crc_upd;
  logic [8:0]  count_inc;
  logic [15:0] ticks_dec;
  logic [15:0] gap_inc;
  logic [2:0]  close_status;

  mrtu_crc_byte u_crc (
    .crc_in  (running_crc),
    .data    (held0),
    .crc_out (crc_upd)
  );

  assign count_inc = (byte_count < COUNT_MAX) ? byte_count + 9'd1 : byte_count;
  assign ticks_dec = (ticks_left != 16'd0) ? ticks_left - 16'd1 : ticks_left;
  assign gap_inc   = (gap_count < GAP_MAX) ? gap_count + 16'd1 : gap_count;

  // checks in priority order
  always_comb begin
    if (byte_count < MIN_FRAME_LEN) begin
      close_status = ST_SHORT;
    end else if ({held1, held0} != running_crc) begin
      close_status = ST_CRC;
    end else if (address_seen != expected_address) begin
      close_status = ST_ADDR;
    end else begin
      close_status = ST_OK;
    end
  end

  always_comb begin
    phase_next            = phase;
    expected_address_next = expected_address;
    ticks_left_next       = ticks_left;
    gap_count_next        = gap_count;
    byte_count_next       = byte_count;
    running_crc_next      = running_crc;
    held0_next            = held0;
    held1_next            = held1;
    address_seen_next     = address_seen;
    res_valid             = 1'b0;
    res                   = '0;

    case (item.action)
      ACT_START: begin
        expected_address_next = item.unit_id;
        ticks_left_next       = item.timeout_ticks;
        gap_count_next        = 16'd0;
        byte_count_next       = 9'd0;
        running_crc_next      = CRC_INIT;
        held0_next            = 8'd0;
        held1_next            = 8'd0;
        address_seen_next     = 8'd0;
        if (item.timeout_ticks == 16'd0) begin
          phase_next     = PH_IDLE;
          res_valid      = 1'b1;
          res.kind       = KIND_STATUS;
          res.status     = ST_TIMEOUT;
          res.frame_done = 1'b1;
        end else begin
          phase_next = PH_WAIT;
        end
      end
      ACT_BYTE: begin
        if (phase != PH_IDLE) begin
          if (phase == PH_WAIT) begin
            address_seen_next = item.rx_byte;
            phase_next        = PH_RECV;
          end
          held0_next      = held1;
          held1_next      = item.rx_byte;
          gap_count_next  = 16'd0;
          byte_count_next = count_inc;
          // the byte leaving the two-deep hold goes into the crc
          if (byte_count >= 9'd2) begin
            running_crc_next = crc_upd;
            if (byte_count >= 9'd3) begin
              res_valid            = 1'b1;
              res.kind             = KIND_PAYLOAD;
              res.payload_byte     = held0;
              res.is_function_code = (byte_count == 9'd3);
              res.frame_length     = count_inc;
            end
          end
        end
      end
      ACT_TICK: begin
        if (phase != PH_IDLE) begin
          ticks_left_next = ticks_dec;
          if (phase == PH_WAIT) begin
            if (ticks_dec == 16'd0) begin
              phase_next     = PH_IDLE;
              res_valid      = 1'b1;
              res.kind       = KIND_STATUS;
              res.status     = ST_TIMEOUT;
              res.frame_done = 1'b1;
            end
          end else begin
            gap_count_next = gap_inc;
            if (ticks_dec == 16'd0 || gap_inc >= {1'b0, gap_limit}) begin
              phase_next       = PH_IDLE;
              res_valid        = 1'b1;
              res.kind         = KIND_STATUS;
              res.status       = close_status;
              res.frame_done   = 1'b1;
              res.frame_length = byte_count;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      expected_address <= 8'd0;
      ticks_left       <= 16'd0;
      gap_count        <= 16'd0;
      byte_count       <= 9'd0;
      running_crc      <= CRC_INIT;
      held0            <= 8'd0;
      held1            <= 8'd0;
      address_seen     <= 8'd0;
    end else if (step) begin
      phase            <= phase_next;
      expected_address <= expected_address_next;
      ticks_left       <= ticks_left_next;
      gap_count        <= gap_count_next;
      byte_count       <= byte_count_next;
      running_crc      <= running_crc_next;
      held0            <= held0_next;
      held1            <= held1_next;
      address_seen     <= address_seen_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mrtu_checker.sv -----
`default_nettype none

module mrtu_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       kind,
  input wire logic [2:0] status,
  input wire logic       frame_done,
  input wire logic [8:0] frame_length
);
  import mrtu_pkg::*;

  // a result offered and not taken stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // payload results never close a frame and carry no status
  a_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_PAYLOAD |-> !frame_done && status == ST_OK)
    else $error("payload result with status or frame_done");

  // a payload result only comes once address, function code and two more bytes are in
  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_PAYLOAD |-> frame_length >= MIN_FRAME_LEN)
    else $error("payload result too early in frame");

  // every status closes the transaction; timeouts report no bytes
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_STATUS |->
      frame_done && (status != ST_TIMEOUT || frame_length == 9'd0))
    else $error("bad closing status");

  // nothing is offered right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind modbus_rtu_response_receiver_top mrtu_checker u_mrtu_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .kind         (out_ch.kind),
  .status       (out_ch.status),
  .frame_done   (out_ch.frame_done),
  .frame_length (out_ch.frame_length)
);

`default_nettype wire

// ----- verif/mrtu_resp_checker.sv -----
module mrtu_resp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  mrtu_in_if          in_mon,
  mrtu_out_if         out_mon,
  output int          fail_count,
  output int          pending
);
  import mrtu_pkg::*;

  typedef enum logic [1:0] {LINE_IDLE, LINE_WAIT, LINE_RECV} line_phase_t;

  line_phase_t line_phase;
  logic [15:0] silence;
  logic [7:0]  want_addr;
  logic [15:0] deadline_left;
  logic [15:0] gap_ticks;
  logic [8:0]  rx_count;
  logic [15:0] frame_crc;
  logic [7:0]  tail [2];
  logic [7:0]  first_byte;
  out_item_t   response_q [$];

  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic out_item_t status_item(logic [2:0] st, logic [8:0] len);
    out_item_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.status = st;
    r.frame_done = 1'b1;
    r.frame_length = len;
    return r;
  endfunction

  // expected item goes to the back of the queue
  task automatic queue_result(out_item_t r);
    response_q = {response_q, r};
  endtask

  task automatic receiver_predict(in_item_t it);
    logic [15:0] lim;
    logic [8:0]  prev_count;
    logic [7:0]  leaving;
    logic [2:0]  st;
    out_item_t   r;
    lim = ((silence >> 1) < 16'd2) ? 16'd2 : (silence >> 1);
    case (it.action)
      ACT_START: begin
        want_addr = it.unit_id;
        deadline_left = it.timeout_ticks;
        gap_ticks = '0;
        rx_count = '0;
        frame_crc = CRC_INIT;
        tail[0] = '0;
        tail[1] = '0;
        first_byte = '0;
        if (it.timeout_ticks == 16'd0) begin
          line_phase = LINE_IDLE;
          queue_result(status_item(ST_TIMEOUT, 9'd0));
        end else begin
          line_phase = LINE_WAIT;
        end
      end
      ACT_BYTE: if (line_phase != LINE_IDLE) begin
        prev_count = rx_count;
        leaving = tail[0];
        if (line_phase == LINE_WAIT) begin
          first_byte = it.rx_byte;
          line_phase = LINE_RECV;
        end
        tail[0] = tail[1];
        tail[1] = it.rx_byte;
        gap_ticks = '0;
        if (rx_count != COUNT_MAX) rx_count = rx_count + 9'd1;
        // two bytes behind: address then function code leave the window first
        if (prev_count >= 9'd2) begin
          frame_crc = crc16_update(frame_crc, leaving);
          if (prev_count >= 9'd3) begin
            r = '0;
            r.kind = KIND_PAYLOAD;
            r.payload_byte = leaving;
            r.is_function_code = (prev_count == 9'd3);
            r.frame_length = rx_count;
            queue_result(r);
          end
        end
      end
      ACT_TICK: if (line_phase != LINE_IDLE) begin
        if (deadline_left != 16'd0) deadline_left = deadline_left - 16'd1;
        if (line_phase == LINE_WAIT) begin
          if (deadline_left == 16'd0) begin
            line_phase = LINE_IDLE;
            queue_result(status_item(ST_TIMEOUT, 9'd0));
          end
        end else begin
          if (gap_ticks != GAP_MAX) gap_ticks = gap_ticks + 16'd1;
          if (deadline_left == 16'd0 || gap_ticks >= lim) begin
            if (rx_count < MIN_FRAME_LEN) st = ST_SHORT;
            else if ({tail[1], tail[0]} != frame_crc) st = ST_CRC;
            else if (first_byte != want_addr) st = ST_ADDR;
            else st = ST_OK;
            line_phase = LINE_IDLE;
            queue_result(status_item(st, rx_count));
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(string name, logic [8:0] want_v, logic [8:0] got_v);
    if (got_v !== want_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endtask

  task automatic check_response(out_item_t got);
    out_item_t want;
    if (response_q.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected item, expected none, actual kind %0h byte %0h status %0h len %0h",
               $time, got.kind, got.payload_byte, got.status, got.frame_length);
    end else begin
      want = response_q.pop_front();
      compare_field("kind", 9'(want.kind), 9'(got.kind));
      compare_field("payload_byte", 9'(want.payload_byte), 9'(got.payload_byte));
      compare_field("is_function_code", 9'(want.is_function_code),
                    9'(got.is_function_code));
      compare_field("status", 9'(want.status), 9'(got.status));
      compare_field("frame_done", 9'(want.frame_done), 9'(got.frame_done));
      compare_field("frame_length", want.frame_length, got.frame_length);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      line_phase = LINE_IDLE;
      silence = SILENCE_RESET;
      want_addr = '0;
      deadline_left = '0;
      gap_ticks = '0;
      rx_count = '0;
      frame_crc = CRC_INIT;
      tail[0] = '0;
      tail[1] = '0;
      first_byte = '0;
      response_q.delete();
      fail_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready)
        check_response({out_mon.kind, out_mon.payload_byte, out_mon.is_function_code,
                        out_mon.status, out_mon.frame_done, out_mon.frame_length});
      if (cfg_we) silence = cfg_wdata;
      if (in_mon.valid && in_mon.ready)
        receiver_predict({in_mon.action, in_mon.unit_id, in_mon.timeout_ticks, in_mon.rx_byte});
    end
    pending = response_q.size();
  end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  import mrtu_pkg::*;

  // action code the block has no use for
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // watchdog, far above the slowest legal run
  localparam int LIMIT_CYCLES = 300000;
  // long receiver hold-off, enough to back the block up into its input
  localparam int HOLD_CYCLES = 300;
  // random items per silence setting
  localparam int PHASE_ITEMS = 58;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        quiet = 1'b0;     // no idling on either side
  logic        hold_req = 1'b0;  // ask the receiver for one long hold-off
  logic        noise = 1'b0;     // items that mostly get ignored, not counted
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          gap_lim = 2;      // stimulus copy of max(silence/2, 2)
  int          dl_left = 0;      // deadline ticks left, for shaping frames
  int          items_done = 0;
  logic [7:0]  line_bytes [$];   // bytes of the frame about to go on the line
  logic [15:0] silence_plan [7];

  mrtu_in_if  in_ch ();
  mrtu_out_if out_ch ();

  modbus_rtu_response_receiver_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  mrtu_resp_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver side: random stall bursts, plus the one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_ch.ready = 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // crc-16 of line_bytes, used to build well-formed frames
  function automatic logic [15:0] line_crc();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (line_bytes[i]) begin
      c ^= {8'h00, line_bytes[i]};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // one more byte at the end of the frame being built
  task automatic add_line_byte(logic [7:0] b);
    line_bytes = {line_bytes, b};
  endtask

  task automatic append_crc();
    logic [15:0] c;
    c = line_crc();
    // low byte goes first on the line
    add_line_byte(c[7:0]);
    add_line_byte(c[15:8]);
  endtask

  // offer one item, called at a falling edge; unless quiet it may first idle with valid
  // low, then returns at the falling edge after the handshake with valid still high, so the next item need not drop it
  task automatic push_item(logic [1:0] act, logic [7:0] unit, logic [15:0] tmo,
                           logic [7:0] b);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_ch.action = act;
    in_ch.unit_id = unit;
    in_ch.timeout_ticks = tmo;
    in_ch.rx_byte = b;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (act == ACT_START) dl_left = tmo;
    else if (act == ACT_TICK && dl_left > 0) dl_left--;
    if (!noise) items_done++;
  endtask

  // unused fields get random values on ticks and bytes
  task automatic tick_n(int n);
    repeat (n) push_item(ACT_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic start_frame(logic [7:0] unit, logic [15:0] tmo);
    push_item(ACT_START, unit, tmo, 8'($urandom));
  endtask

  // put line_bytes[from..upto-1] on the line, with short gaps below the limit
  task automatic send_line(int from, int upto, int mg);
    for (int i = from; i < upto; i++) begin
      if (i > from && mg > 0) tick_n($urandom_range(0, mg));
      push_item(ACT_BYTE, 8'($urandom), 16'($urandom), line_bytes[i]);
    end
  endtask

  // silence after the last byte: gap limit or deadline, whichever comes first
  task automatic close_line();
    tick_n((dl_left < gap_lim) ? dl_left : gap_lim);
  endtask

  // stop offering, wait for every expected item, then let the pipeline settle
  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // a zero deadline start answers at once and leaves the block idle
  task automatic write_silence(logic [15:0] v);
    start_frame(8'h00, 16'd0);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    gap_lim = (v / 2 < 2) ? 2 : v / 2;
  endtask

  // one response transaction; mostly well formed, some broken on purpose
  task automatic random_transaction();
    int pick;
    int ndata;
    int mg;
    int cut;
    logic [7:0]  unit;
    logic [15:0] tmo;
    pick = $urandom_range(0, 99);
    unit = 8'($urandom);
    ndata = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    mg = (gap_lim - 1 < 4) ? gap_lim - 1 : 4;
    // with a huge gap limit the deadline is what ends the frame
    tmo = (gap_lim > 40) ? 16'($urandom_range(40, 120)) : 16'($urandom_range(300, 65535));
    if (pick >= 75 && pick < 81) begin
      // nobody answers: deadline runs out before a first byte
      tmo = 16'($urandom_range(1, 12));
      start_frame(unit, tmo);
      tick_n(tmo);
      return;
    end
    if (pick >= 81 && pick < 87) begin
      // junk items, including the unused action code
      noise = 1'b1;
      repeat ($urandom_range(1, 4))
        push_item(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom), 8'($urandom));
      noise = 1'b0;
      return;
    end
    line_bytes.delete();
    if (pick >= 69 && pick < 75) begin
      // too short to carry a crc
      repeat ($urandom_range(1, 3)) add_line_byte(8'($urandom));
    end else begin
      // wrong responder address for picks 63..68
      add_line_byte((pick >= 63 && pick < 69) ? unit ^ 8'($urandom_range(1, 255)) : unit);
      add_line_byte(8'($urandom));
      repeat (ndata) add_line_byte(8'($urandom));
      append_crc();
      // one flipped bit anywhere breaks the crc
      if (pick >= 55 && pick < 63)
        line_bytes[$urandom_range(0, line_bytes.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
    end
    start_frame(unit, tmo);
    tick_n($urandom_range(0, 2));
    cut = $urandom_range(1, line_bytes.size() - 1);
    if (pick >= 87 && pick < 93) begin
      // abandoned mid-frame: the next start drops it
      send_line(0, cut, mg);
    end else if (pick >= 93) begin
      // a gap splits the frame; the tail lands on an idle block
      send_line(0, cut, mg);
      close_line();
      send_line(cut, line_bytes.size(), mg);
      close_line();
    end else begin
      send_line(0, line_bytes.size(), mg);
      close_line();
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_TICK;
    in_ch.unit_id = '0;
    in_ch.timeout_ticks = '0;
    in_ch.rx_byte = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // directed part, silence at its reset value of 4

    // idle block ignores ticks, bytes and the unused action code
    push_item(ACT_TICK, 8'h00, 16'h0000, 8'h00);
    push_item(ACT_BYTE, 8'hFF, 16'hFFFF, 8'hFF);
    push_item(ACT_UNUSED, 8'hA5, 16'h5A5A, 8'h3C);

    // zero deadline: timeout status straight away
    start_frame(8'h00, 16'd0);

    // clean response at the top address and longest deadline, extreme data bytes
    line_bytes = {8'hFF, 8'h03, 8'h00, 8'hFF};
    append_crc();
    start_frame(8'hFF, 16'hFFFF);
    send_line(0, line_bytes.size(), 0);
    close_line();

    // deadline runs out while still waiting for a first byte
    start_frame(8'h11, 16'd3);
    tick_n(3);

    // deadline runs out in the middle of a two byte frame
    start_frame(8'h5A, 16'd1);
    push_item(ACT_BYTE, 8'h00, 16'h0000, 8'h5A);
    push_item(ACT_BYTE, 8'h00, 16'h0000, 8'h01);
    tick_n(1);

    // start while busy: the half frame is dropped without a word
    start_frame(8'h01, 16'd100);
    push_item(ACT_BYTE, 8'h00, 16'h0000, 8'h01);
    start_frame(8'h01, 16'd100);
    drain();

    // oversize frame so the length saturates; the receiver holds off meanwhile
    // so the output backs up and the input stalls
    line_bytes = {8'h22, 8'h10};
    repeat (516) add_line_byte(8'($urandom));
    append_crc();
    start_frame(8'h22, 16'hFFFF);
    hold_req = 1'b1;
    send_line(0, line_bytes.size(), 0);
    close_line();
    // sender pauses until every expected item is back
    drain();

    // random part, one stretch per silence setting; extremes included,
    // the last stretch back at the reset value and with no idling at all
    silence_plan = '{16'd1, 16'hFFFF, 16'd3, 16'd2, 16'd0, 16'd6, 16'd4};
    silence_plan[4] = 16'($urandom_range(7, 200));
    foreach (silence_plan[p]) begin
      if (p == 6) quiet = 1'b1;
      write_silence(silence_plan[p]);
      items_done = 0;
      while (items_done < PHASE_ITEMS) random_transaction();
    end

    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
